FILE: rtl/rrip_pkg.sv
// Shared types and constants for the RRIP set replacement block.
package rrip_pkg;

	localparam int RRPV_W = 3;
	localparam int ACTION_W = 2;
	localparam int SET_IDX_W = 10;
	localparam int WAY_W = 4;
	localparam int CLASS_W = 3;

	typedef logic [RRPV_W-1:0] rrpv_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [CLASS_W-1:0] class_t;

	localparam action_t ACT_INVALIDATE = 2'd0;
	localparam action_t ACT_HIT = 2'd1;
	localparam action_t ACT_FILL = 2'd2;
	localparam action_t ACT_VICTIM = 2'd3;

	localparam class_t CLS_NONE = 3'd0;
	localparam class_t CLS_NONPROP = 3'd1;
	localparam class_t CLS_HIGH = 3'd2;
	localparam class_t CLS_MODERATE = 3'd3;

	localparam rrpv_t FILL_NONPROP = 3'd2;
	localparam rrpv_t FILL_HIGH = 3'd1;
	localparam rrpv_t RESET_RRPV = 3'd3;

	typedef struct packed {
		action_t action;
		way_t way;
		class_t cls;
		rrpv_t max_val;
	} rrip_op_t;

endpackage

FILE: rtl/rrip_ram.sv
// Generic simple dual-port RAM with registered read.
module rrip_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/rrip_row_upd.sv
// Row update: per-way prediction change and victim search with aging.
module rrip_row_upd
	import rrip_pkg::*;
#(
	parameter int NUM_WAYS = 16
) (
	input  logic [NUM_WAYS*RRPV_W-1:0] row,
	input  rrip_op_t op,
	output logic [NUM_WAYS*RRPV_W-1:0] new_row,
	output way_t victim_way
);

	localparam int WAY_IW = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;

	rrpv_t lane [NUM_WAYS];
	logic [(1 << RRPV_W)-2:0] ge;
	rrpv_t top;
	rrpv_t thr;
	rrpv_t delta;
	logic aging;
	rrpv_t fill_val;
	logic [WAY_IW-1:0] vidx;

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			lane[w] = row[w*RRPV_W +: RRPV_W];
		end
	end

	always_comb begin
		ge = '0;
		for (int t = 1; t < (1 << RRPV_W); t++) begin
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (lane[w] >= RRPV_W'(t)) begin
					ge[t-1] = 1'b1;
				end
			end
		end
		top = RRPV_W'($countones(ge));
		aging = top < op.max_val;
		thr = aging ? top : op.max_val;
		delta = op.max_val - top;
	end

	always_comb begin
		unique case (op.cls) inside
			CLS_NONE, CLS_MODERATE: fill_val = op.max_val - rrpv_t'(1);
			CLS_NONPROP: fill_val = FILL_NONPROP;
			CLS_HIGH: fill_val = FILL_HIGH;
			default: fill_val = op.max_val;
		endcase
	end

	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++) begin
			new_row[w*RRPV_W +: RRPV_W] = lane[w];
			unique case (op.action)
				ACT_VICTIM: begin
					if (aging) begin
						new_row[w*RRPV_W +: RRPV_W] = lane[w] + delta;
					end
				end
				ACT_INVALIDATE: begin
					if (6'(op.way) == 6'(w)) begin
						new_row[w*RRPV_W +: RRPV_W] = op.max_val;
					end
				end
				ACT_HIT: begin
					if (6'(op.way) == 6'(w) && lane[w] != '0) begin
						new_row[w*RRPV_W +: RRPV_W] = lane[w] - rrpv_t'(1);
					end
				end
				ACT_FILL: begin
					if (6'(op.way) == 6'(w)) begin
						new_row[w*RRPV_W +: RRPV_W] = fill_val;
					end
				end
			endcase
		end
	end

	always_comb begin
		vidx = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (lane[w] >= thr) begin
				vidx = WAY_IW'(w);
			end
		end
		victim_way = (op.action == ACT_VICTIM) ? WAY_W'(vidx) : '0;
	end

endmodule

FILE: rtl/rrip_set_replacement_top.sv
// RRIP set replacement: top level with row memory, sequencer and output stage.
//
// Each transaction goes through accept, set-index reduction with the row
// read, then row update with writeback and result. One transaction is in work
// at a time; the next is accepted while the previous result waits at the
// output. After reset a clearing pass writes every row of the memory, one row
// a cycle, with s_axis_tready low; the max_value register may be written
// meanwhile. Results appear in order, one per input transaction: victim_valid
// in tuser, victim_way in tdata.
module rrip_set_replacement_top
	import rrip_pkg::*;
#(
	parameter int NUM_SETS = 1024,
	parameter int NUM_WAYS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata, // set_index[9:0], way[13:10], insert_class[16:14], zero
	input  logic [1:0] s_axis_tuser,  // action[1:0]
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [7:0] m_axis_tdata,  // victim_way[3:0], zero
	output logic [0:0] m_axis_tuser,  // victim_valid[0]
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_data
);

	localparam int SET_AW = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
	localparam int ROW_W = NUM_WAYS * RRPV_W;
	localparam int RECIP_SH = 20;
	localparam int RECIP_W = RECIP_SH + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** RECIP_SH + NUM_SETS - 1) / NUM_SETS);
	localparam logic [SET_IDX_W-1:0] NSETS_LO = SET_IDX_W'(NUM_SETS % 1024);
	localparam logic [ROW_W-1:0] RESET_ROW = {NUM_WAYS{RESET_RRPV}};

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_IDX = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;

	logic [1:0] state_q;
	rrpv_t max_q;
	logic clr_busy_q;
	logic [SET_AW-1:0] clr_cnt_q;

	action_t action_s1;
	way_t way_s1;
	class_t cls_s1;
	logic [SET_IDX_W-1:0] set_s1;
	logic [SET_IDX_W-1:0] quo_s1;
	logic [SET_AW-1:0] addr_s2;

	logic m_valid_q;
	way_t m_way_q;
	logic m_vld_flag_q;
	logic pend_q;
	way_t pend_way_q;
	logic pend_flag_q;

	logic in_acc;
	logic out_free;
	logic [RECIP_W+SET_IDX_W-1:0] prod;
	logic [SET_IDX_W-1:0] qn;
	logic [SET_IDX_W-1:0] rem;
	logic [SET_AW-1:0] rd_addr;
	logic ram_we;
	logic [SET_AW-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [ROW_W-1:0] row_rd;
	logic [ROW_W-1:0] row_new;
	rrip_op_t op;
	way_t upd_victim;

	assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy_q && !pend_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !m_valid_q || m_axis_tready;

	assign prod = {{RECIP_W{1'b0}}, s_axis_tdata[SET_IDX_W-1:0]}
		* {{SET_IDX_W{1'b0}}, RECIP};
	assign qn = quo_s1 * NSETS_LO;
	assign rem = set_s1 - qn;
	assign rd_addr = SET_AW'(rem);

	assign op = '{action: action_s1, way: way_s1, cls: cls_s1, max_val: max_q};

	assign ram_we = clr_busy_q || (state_q == ST_CALC);
	assign ram_waddr = clr_busy_q ? clr_cnt_q : addr_s2;
	assign ram_wdata = clr_busy_q ? RESET_ROW : row_new;

	rrip_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_row_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr),
		.rdata(row_rd)
	);

	rrip_row_upd #(
		.NUM_WAYS(NUM_WAYS)
	) u_row_upd (
		.row(row_rd),
		.op(op),
		.new_row(row_new),
		.victim_way(upd_victim)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q <= RESET_RRPV;
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				max_q <= (cfg_data == '0) ? rrpv_t'(1) : cfg_data;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + SET_AW'(1);
				if (clr_cnt_q == SET_AW'(NUM_SETS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_IDX;
					end
				end
				ST_IDX: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1 <= s_axis_tuser;
			set_s1 <= s_axis_tdata[SET_IDX_W-1:0];
			way_s1 <= s_axis_tdata[SET_IDX_W +: WAY_W];
			cls_s1 <= s_axis_tdata[SET_IDX_W+WAY_W +: CLASS_W];
			quo_s1 <= prod[RECIP_SH +: SET_IDX_W];
		end
		if (state_q == ST_IDX) begin
			addr_s2 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (state_q == ST_CALC) begin
				if (out_free) begin
					m_valid_q <= 1'b1;
				end else begin
					pend_q <= 1'b1;
				end
			end else if (pend_q && out_free) begin
				m_valid_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			if (out_free) begin
				m_way_q <= upd_victim;
				m_vld_flag_q <= (action_s1 == ACT_VICTIM);
			end else begin
				pend_way_q <= upd_victim;
				pend_flag_q <= (action_s1 == ACT_VICTIM);
			end
		end else if (pend_q && out_free) begin
			m_way_q <= pend_way_q;
			m_vld_flag_q <= pend_flag_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {4'b0, m_way_q};
	assign m_axis_tuser = m_vld_flag_q;

	a_max_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		max_q != '0)
		else $error("max_value register holds zero");

	a_idx_then_calc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDX |=> state_q == ST_CALC)
		else $error("row read not followed by writeback");

	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> state_q == ST_IDLE)
		else $error("transaction in work during clearing pass");

	a_pend_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> m_valid_q)
		else $error("pending result with empty output register");

	a_calc_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> !pend_q)
		else $error("result produced with pending slot occupied");

endmodule
